FILE: design/jsrp_pkg.sv
// jsrp_pkg: shared types and constants of the joint state record parser
// section encoding, field kind codes, assembler control/status structs
// no dependencies
package jsrp_pkg;

  localparam int KIND_W  = 4;
  localparam int VALUE_W = 64;
  localparam int INDEX_W = 32;
  localparam int WORD_W  = 32;

  // one-hot parse section
  typedef enum logic [15:0] {
    SEC_IDLE      = 16'h0001,
    SEC_SEQ       = 16'h0002,
    SEC_SEC       = 16'h0004,
    SEC_NSEC      = 16'h0008,
    SEC_ID_LEN    = 16'h0010,
    SEC_ID_CHAR   = 16'h0020,
    SEC_NAME_CNT  = 16'h0040,
    SEC_NAME_LEN  = 16'h0080,
    SEC_NAME_CHAR = 16'h0100,
    SEC_POS_CNT   = 16'h0200,
    SEC_POS_VAL   = 16'h0400,
    SEC_VEL_CNT   = 16'h0800,
    SEC_VEL_VAL   = 16'h1000,
    SEC_EFF_CNT   = 16'h2000,
    SEC_EFF_VAL   = 16'h4000,
    SEC_DONE      = 16'h8000
  } section_t;

  localparam logic [KIND_W-1:0] KIND_SEQ       = 4'd0;
  localparam logic [KIND_W-1:0] KIND_SEC       = 4'd1;
  localparam logic [KIND_W-1:0] KIND_NSEC      = 4'd2;
  localparam logic [KIND_W-1:0] KIND_ID_LEN    = 4'd3;
  localparam logic [KIND_W-1:0] KIND_ID_CHAR   = 4'd4;
  localparam logic [KIND_W-1:0] KIND_NAME_CNT  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_NAME_LEN  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_NAME_CHAR = 4'd7;
  localparam logic [KIND_W-1:0] KIND_POS_CNT   = 4'd8;
  localparam logic [KIND_W-1:0] KIND_POS_VAL   = 4'd9;
  localparam logic [KIND_W-1:0] KIND_VEL_CNT   = 4'd10;
  localparam logic [KIND_W-1:0] KIND_VEL_VAL   = 4'd11;
  localparam logic [KIND_W-1:0] KIND_EFF_CNT   = 4'd12;
  localparam logic [KIND_W-1:0] KIND_EFF_VAL   = 4'd13;

  // byte assembler control
  typedef struct packed {
    logic restart;  // packet start: drop partial word
    logic shift;    // take this byte into the word
    logic wide;     // 8-byte double instead of 4-byte word
  } asm_ctrl_t;

  typedef struct packed {
    logic               complete;
    logic [VALUE_W-1:0] value;
  } asm_stat_t;

  function automatic logic [KIND_W-1:0] kind_of(input section_t sec);
    logic [KIND_W-1:0] k;
    k = KIND_SEQ;
    unique case (sec)
      SEC_SEQ:       k = KIND_SEQ;
      SEC_SEC:       k = KIND_SEC;
      SEC_NSEC:      k = KIND_NSEC;
      SEC_ID_LEN:    k = KIND_ID_LEN;
      SEC_ID_CHAR:   k = KIND_ID_CHAR;
      SEC_NAME_CNT:  k = KIND_NAME_CNT;
      SEC_NAME_LEN:  k = KIND_NAME_LEN;
      SEC_NAME_CHAR: k = KIND_NAME_CHAR;
      SEC_POS_CNT:   k = KIND_POS_CNT;
      SEC_POS_VAL:   k = KIND_POS_VAL;
      SEC_VEL_CNT:   k = KIND_VEL_CNT;
      SEC_VEL_VAL:   k = KIND_VEL_VAL;
      SEC_EFF_CNT:   k = KIND_EFF_CNT;
      SEC_EFF_VAL:   k = KIND_EFF_VAL;
      default:       k = KIND_SEQ;
    endcase
    return k;
  endfunction

endpackage

FILE: design/jsrp_word_asm.sv
// jsrp_word_asm: big-endian byte to word assembler (4 or 8 bytes)
// depends on jsrp_pkg
module jsrp_word_asm (
  input  logic                clk,
  input  logic                rst_n,
  input  jsrp_pkg::asm_ctrl_t ctrl,
  input  logic [7:0]          data_byte,
  output jsrp_pkg::asm_stat_t stat
);
  import jsrp_pkg::*;

  logic [VALUE_W-1:0] word_r, word_nxt;
  logic [2:0]         pos_r, pos_nxt;
  logic [VALUE_W-1:0] base_word;
  logic [2:0]         base_pos;
  logic [VALUE_W-1:0] shifted;
  logic               last_byte;

  assign base_word = ctrl.restart ? '0 : word_r;
  assign base_pos  = ctrl.restart ? '0 : pos_r;
  assign shifted   = {base_word[VALUE_W-9:0], data_byte};
  assign last_byte = ctrl.wide ? (base_pos == 3'd7) : (base_pos == 3'd3);

  assign stat.complete = ctrl.shift && last_byte;
  assign stat.value    = shifted;

  always_comb begin
    word_nxt = base_word;
    pos_nxt  = base_pos;
    if (ctrl.shift) begin
      if (last_byte) begin
        word_nxt = '0;
        pos_nxt  = '0;
      end else begin
        word_nxt = shifted;
        pos_nxt  = base_pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
      pos_r  <= '0;
    end else begin
      word_r <= word_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

FILE: design/joint_state_record_parser_unit.sv
// Joint state record parser. Takes one packet byte per transaction and decodes the record:
// seq, sec, nsec header words, a length-prefixed frame id, a counted list of names, and
// position, velocity and effort arrays of big-endian doubles. Every finished word, character
// or double gives one result transaction tagged with its kind and index; packet_done marks the
// last one. A byte can be accepted every cycle: the parse state and result register update
// together at the accepting edge, so the only stall comes from a held result register. Counts
// with bit 31 set act as zero; counts above 2^COUNT_WIDTH-1 saturate. Bytes outside a packet
// are dropped until in_packet_start.
// depends on jsrp_pkg and jsrp_word_asm
module joint_state_record_parser_unit #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_packet_start,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [jsrp_pkg::KIND_W-1:0]    out_field_kind,
  output logic [jsrp_pkg::VALUE_W-1:0]   out_field_value,
  output logic [jsrp_pkg::INDEX_W-1:0]   out_element_index,
  output logic                           out_packet_done
);
  import jsrp_pkg::*;

  section_t               section_r, section_nxt, sec;
  logic [COUNT_WIDTH-1:0] elem_rem_r, elem_rem_nxt;
  logic [COUNT_WIDTH-1:0] char_rem_r, char_rem_nxt;
  logic [COUNT_WIDTH-1:0] elem_cnt_r, elem_cnt_nxt;
  logic [COUNT_WIDTH-1:0] char_cnt_r, char_cnt_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]      kind_r;
  logic [VALUE_W-1:0]     value_r;
  logic [INDEX_W-1:0]     index_r;
  logic                   done_r;

  logic                   accept, active, is_char, emit, emit_done;
  logic [INDEX_W-1:0]     emit_index;
  logic [VALUE_W-1:0]     emit_value;
  logic [WORD_W-1:0]      word;
  logic [COUNT_WIDTH-1:0] n;
  logic                   n_zero;
  asm_ctrl_t              asm_ctrl;
  asm_stat_t              asm_stat;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign sec      = in_packet_start ? SEC_SEQ : section_r;
  assign active   = accept && (sec != SEC_IDLE) && (sec != SEC_DONE);
  assign is_char  = (sec == SEC_ID_CHAR) || (sec == SEC_NAME_CHAR);

  assign asm_ctrl.restart = accept && in_packet_start;
  assign asm_ctrl.shift   = active && !is_char;
  assign asm_ctrl.wide    = (sec == SEC_POS_VAL) || (sec == SEC_VEL_VAL) || (sec == SEC_EFF_VAL);

  jsrp_word_asm u_asm (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (asm_ctrl),
    .data_byte (in_data_byte),
    .stat      (asm_stat)
  );

  // count decode: negative acts as zero, too large saturates
  assign word   = asm_stat.value[WORD_W-1:0];
  assign n      = word[WORD_W-1] ? '0 :
                  ((word >> COUNT_WIDTH) != '0) ? '1 : word[COUNT_WIDTH-1:0];
  assign n_zero = (n == '0);

  assign emit_value = is_char ? VALUE_W'(in_data_byte) : asm_stat.value;

  always_comb begin
    section_nxt  = section_r;
    elem_rem_nxt = elem_rem_r;
    char_rem_nxt = char_rem_r;
    elem_cnt_nxt = elem_cnt_r;
    char_cnt_nxt = char_cnt_r;
    emit         = 1'b0;
    emit_done    = 1'b0;
    emit_index   = '0;
    if (accept && in_packet_start) begin
      section_nxt  = SEC_SEQ;
      elem_rem_nxt = '0;
      char_rem_nxt = '0;
      elem_cnt_nxt = '0;
      char_cnt_nxt = '0;
    end
    if (active && is_char) begin
      emit         = 1'b1;
      emit_index   = INDEX_W'(char_cnt_r);
      char_cnt_nxt = char_cnt_r + 1'b1;
      char_rem_nxt = char_rem_r - 1'b1;
      if (char_rem_r == COUNT_WIDTH'(1)) begin
        if (sec == SEC_ID_CHAR) begin
          section_nxt = SEC_NAME_CNT;
        end else begin
          elem_cnt_nxt = elem_cnt_r + 1'b1;
          elem_rem_nxt = elem_rem_r - 1'b1;
          section_nxt  = (elem_rem_r == COUNT_WIDTH'(1)) ? SEC_POS_CNT : SEC_NAME_LEN;
        end
      end
    end else if (active && asm_stat.complete) begin
      emit = 1'b1;
      unique case (sec)
        SEC_SEQ:  section_nxt = SEC_SEC;
        SEC_SEC:  section_nxt = SEC_NSEC;
        SEC_NSEC: section_nxt = SEC_ID_LEN;
        SEC_ID_LEN: begin
          char_rem_nxt = n;
          char_cnt_nxt = '0;
          section_nxt  = n_zero ? SEC_NAME_CNT : SEC_ID_CHAR;
        end
        SEC_NAME_CNT: begin
          elem_rem_nxt = n;
          elem_cnt_nxt = '0;
          section_nxt  = n_zero ? SEC_POS_CNT : SEC_NAME_LEN;
        end
        SEC_NAME_LEN: begin
          emit_index   = INDEX_W'(elem_cnt_r);
          char_rem_nxt = n;
          char_cnt_nxt = '0;
          if (!n_zero) begin
            section_nxt = SEC_NAME_CHAR;
          end else begin
            // empty name closes at once
            elem_cnt_nxt = elem_cnt_r + 1'b1;
            elem_rem_nxt = elem_rem_r - 1'b1;
            section_nxt  = (elem_rem_r == COUNT_WIDTH'(1)) ? SEC_POS_CNT : SEC_NAME_LEN;
          end
        end
        SEC_POS_CNT: begin
          elem_rem_nxt = n;
          elem_cnt_nxt = '0;
          section_nxt  = n_zero ? SEC_VEL_CNT : SEC_POS_VAL;
        end
        SEC_VEL_CNT: begin
          elem_rem_nxt = n;
          elem_cnt_nxt = '0;
          section_nxt  = n_zero ? SEC_EFF_CNT : SEC_VEL_VAL;
        end
        SEC_EFF_CNT: begin
          elem_rem_nxt = n;
          elem_cnt_nxt = '0;
          section_nxt  = n_zero ? SEC_DONE : SEC_EFF_VAL;
          emit_done    = n_zero;
        end
        SEC_POS_VAL, SEC_VEL_VAL, SEC_EFF_VAL: begin
          emit_index   = INDEX_W'(elem_cnt_r);
          elem_cnt_nxt = elem_cnt_r + 1'b1;
          elem_rem_nxt = elem_rem_r - 1'b1;
          if (elem_rem_r == COUNT_WIDTH'(1)) begin
            unique case (sec)
              SEC_POS_VAL: section_nxt = SEC_VEL_CNT;
              SEC_VEL_VAL: section_nxt = SEC_EFF_CNT;
              default: begin
                section_nxt = SEC_DONE;
                emit_done   = 1'b1;
              end
            endcase
          end
        end
        default: section_nxt = SEC_IDLE;
      endcase
    end
  end

  assign out_valid_nxt = emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      section_r   <= SEC_IDLE;
      elem_rem_r  <= '0;
      char_rem_r  <= '0;
      elem_cnt_r  <= '0;
      char_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      section_r   <= section_nxt;
      elem_rem_r  <= elem_rem_nxt;
      char_rem_r  <= char_rem_nxt;
      elem_cnt_r  <= elem_cnt_nxt;
      char_cnt_r  <= char_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r  <= kind_of(sec);
      value_r <= emit_value;
      index_r <= emit_index;
      done_r  <= emit_done;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_field_kind    = kind_r;
  assign out_field_value   = value_r;
  assign out_element_index = index_r;
  assign out_packet_done   = done_r;

endmodule

FILE: design/jsrp_checker.sv
// jsrp_checker: port-level assertions for joint_state_record_parser_unit
// depends on jsrp_pkg; bound to the top level below
module jsrp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [jsrp_pkg::KIND_W-1:0]  out_field_kind,
  input logic [jsrp_pkg::VALUE_W-1:0] out_field_value,
  input logic [jsrp_pkg::INDEX_W-1:0] out_element_index,
  input logic                         out_packet_done
);
  import jsrp_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_field_value))
    else $error("stalled result changed");

  // a fresh result needs an input transaction on the edge before
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result without input transaction");

  // only the effort section can close the record
  a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_packet_done |->
      (out_field_kind == KIND_EFF_CNT) || (out_field_kind == KIND_EFF_VAL))
    else $error("packet_done on wrong kind");

  // header words and counts carry index zero
  a_hdr_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_field_kind == KIND_SEQ) || (out_field_kind == KIND_SEC) ||
      (out_field_kind == KIND_NSEC) || (out_field_kind == KIND_ID_LEN) ||
      (out_field_kind == KIND_NAME_CNT) || (out_field_kind == KIND_POS_CNT) ||
      (out_field_kind == KIND_VEL_CNT) || (out_field_kind == KIND_EFF_CNT))
      |-> out_element_index == '0)
    else $error("nonzero index on header or count");

  // characters are single bytes
  a_char_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_field_kind == KIND_ID_CHAR) || (out_field_kind == KIND_NAME_CHAR))
      |-> out_field_value[VALUE_W-1:8] == '0)
    else $error("character wider than a byte");

endmodule

bind joint_state_record_parser_unit jsrp_checker u_jsrp_checker (.*);
